// File: src/dllm_pkg.sv
// shared types, constants and helpers for the doubly linked list manager
package dllm_pkg;

  localparam int NODES  = 256;
  localparam int IDX_W  = $clog2(NODES);
  localparam int LINK_W = $clog2(NODES + 1);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [2:0]        kind_t;

  // link value that means no node
  localparam link_t NONE_ID = link_t'(NODES);

  // request kinds
  localparam kind_t KIND_PUSH_FRONT = 3'd0;
  localparam kind_t KIND_PUSH_BACK  = 3'd1;
  localparam kind_t KIND_INSERT     = 3'd2;
  localparam kind_t KIND_UNLINK     = 3'd3;
  localparam kind_t KIND_POP        = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_INSERT,
    OP_UNLINK,
    OP_POP
  } op_t;

  typedef struct packed {
    kind_t kind;
    idx_t  node_index;
    idx_t  after_index;
    logic  after_present;
  } in_t;

  typedef struct packed {
    idx_t  taken_node;
    logic  taken_valid;
    link_t head_node;
    link_t tail_node;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic link_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_blocked;
  } sts_t;

  function automatic logic is_node(link_t l);
    return l < NONE_ID;
  endfunction

endpackage

// File: src/dllm_ctrl.sv
// sequencer for the link manager: accept, first write slot, final write slot
module dllm_ctrl import dllm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LINK = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.link_step = 1'b0;
    cmd.finish    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        cmd.link_step = 1'b1;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_blocked) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/dllm_dp.sv
// link memories, head and tail registers, write steering and result register
module dllm_dp import dllm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  in_t  in_data,
  output sts_t sts,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  link_t prev_mem [NODES];
  link_t next_mem [NODES];

  link_t prev_q, next_q;
  op_t   op_r, op_in;
  idx_t  node_r, after_r;
  link_t head_r, tail_r, head_nxt, tail_nxt;
  logic  out_valid_r;
  out_t  out_data_r;

  idx_t  next_ra;
  logic  prev_we, next_we;
  idx_t  prev_wa, next_wa;
  link_t prev_wd, next_wd;
  idx_t  taken;
  logic  taken_ok;

  link_t n_link, a_link;
  logic  solo, pop_live, pop_multi;

  // request decode
  always_comb begin
    unique case (in_data.kind)
      KIND_PUSH_FRONT: op_in = OP_PUSH_FRONT;
      KIND_PUSH_BACK:  op_in = OP_PUSH_BACK;
      KIND_INSERT:     op_in = in_data.after_present ? OP_INSERT : OP_PUSH_FRONT;
      KIND_UNLINK:     op_in = OP_UNLINK;
      KIND_POP:        op_in = OP_POP;
      default:         op_in = OP_NOP;
    endcase
  end

  always_comb begin
    case (op_in)
      OP_INSERT: next_ra = in_data.after_index;
      OP_POP:    next_ra = head_r[IDX_W-1:0];
      default:   next_ra = in_data.node_index;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_in;
      node_r  <= in_data.node_index;
      after_r <= in_data.after_index;
      prev_q  <= prev_mem[in_data.node_index];
      next_q  <= next_mem[next_ra];
    end
  end

  assign n_link    = link_t'(node_r);
  assign a_link    = link_t'(after_r);
  assign solo      = (head_r == n_link) && (tail_r == n_link);
  assign pop_live  = is_node(head_r);
  assign pop_multi = pop_live && (head_r != tail_r);

  // write steering; next_q and prev_q hold the links read at accept
  always_comb begin
    prev_we  = 1'b0;
    prev_wa  = node_r;
    prev_wd  = NONE_ID;
    next_we  = 1'b0;
    next_wa  = node_r;
    next_wd  = NONE_ID;
    head_nxt = head_r;
    tail_nxt = tail_r;
    taken    = '0;
    taken_ok = 1'b0;
    if (cmd.link_step) begin
      case (op_r)
        OP_PUSH_FRONT: begin
          prev_we = 1'b1;
          next_we = 1'b1;
          next_wd = head_r;
        end
        OP_PUSH_BACK: begin
          prev_we = 1'b1;
          prev_wd = tail_r;
          next_we = 1'b1;
        end
        OP_INSERT: begin
          prev_we = 1'b1;
          prev_wd = a_link;
          next_we = 1'b1;
          next_wd = next_q;
        end
        OP_UNLINK: begin
          if (!solo) begin
            prev_we = is_node(next_q);
            prev_wa = next_q[IDX_W-1:0];
            prev_wd = prev_q;
            next_we = is_node(prev_q);
            next_wa = prev_q[IDX_W-1:0];
            next_wd = next_q;
          end
        end
        OP_POP: begin
          if (pop_multi) begin
            prev_we = is_node(next_q);
            prev_wa = next_q[IDX_W-1:0];
          end
        end
        default: ;
      endcase
    end
    if (cmd.finish) begin
      case (op_r)
        OP_PUSH_FRONT: begin
          prev_we  = is_node(head_r);
          prev_wa  = head_r[IDX_W-1:0];
          prev_wd  = n_link;
          head_nxt = n_link;
          if (tail_r == NONE_ID) tail_nxt = n_link;
        end
        OP_PUSH_BACK: begin
          next_we  = is_node(tail_r);
          next_wa  = tail_r[IDX_W-1:0];
          next_wd  = n_link;
          tail_nxt = n_link;
          if (head_r == NONE_ID) head_nxt = n_link;
        end
        OP_INSERT: begin
          prev_we = is_node(next_q);
          prev_wa = next_q[IDX_W-1:0];
          prev_wd = n_link;
          next_we = 1'b1;
          next_wa = after_r;
          next_wd = n_link;
          if (tail_r == a_link) tail_nxt = n_link;
        end
        OP_UNLINK: begin
          prev_we = 1'b1;
          next_we = 1'b1;
          if (solo) begin
            head_nxt = NONE_ID;
            tail_nxt = NONE_ID;
          end else begin
            if (head_r == n_link) head_nxt = next_q;
            if (tail_r == n_link) tail_nxt = prev_q;
          end
        end
        OP_POP: begin
          if (pop_multi) begin
            prev_we  = 1'b1;
            prev_wa  = head_r[IDX_W-1:0];
            next_we  = 1'b1;
            next_wa  = head_r[IDX_W-1:0];
            head_nxt = next_q;
          end else if (pop_live) begin
            head_nxt = NONE_ID;
            tail_nxt = NONE_ID;
          end
          if (pop_live) begin
            taken    = head_r[IDX_W-1:0];
            taken_ok = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NONE_ID;
      tail_r      <= NONE_ID;
      out_valid_r <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= '{taken_node: taken, taken_valid: taken_ok,
                      head_node: head_nxt, tail_node: tail_nxt};
    end
  end

  assign sts.out_blocked = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule

// File: src/doubly_linked_list_manager_top.sv
// top level of the doubly linked list manager: controller plus datapath
//
//   channel | dir | payload | handshake
//   in_     | in  | in_t    | in_valid / in_stall, beat on valid && !stall
//   out_    | out | out_t   | out_valid / out_stall, beat on valid && !stall
//
// an item runs accept, link and finish steps: accept reads the links it needs,
// then link and finish each give one write slot on the prev and next memories
// the final slot waits while the result register is full and stalled
// reset clears head, tail, the result valid and the sequencer; link memories are not cleared
// a result waits in its own register, so the next beat can come in meanwhile
module doubly_linked_list_manager_top import dllm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: idle, link step, finish step
  dllm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // link memories, list ends and the result register
  dllm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // an accepted beat blocks the input until its work is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // the link step always follows the accept cycle
  a_load_then_link: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.link_step)
    else $error("link step missing after accept");

  // the finish step lands a result in the output register
  a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finished item produced no result");

  // the finish step never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

endmodule
